>>> rtl/kpi_pkg.sv
// Shared types, widths and codes for the keyframe path interpolator.
// No dependencies; every other file imports this package.
package kpi_pkg;

  localparam int KPI_MAX_KEYFRAMES = 8;

  localparam int VAL_W     = 20;  // signed Q12.8 pose values
  localparam int TIME_W    = 20;  // unsigned Q12.8 times
  localparam int IDX_W     = 3;   // key_index field
  localparam int CFG_W     = 4;   // keyframes_in_use register
  localparam int SEG_W     = 3;   // segment output field
  localparam int FRAC_BITS = 16;  // fraction in Q0.16
  localparam int FRAC_W    = FRAC_BITS + 1;  // holds 1.0 as well
  localparam int NUM_LANES = 5;   // x, y, z, yaw, pitch
  localparam int LANE_W    = 3;   // counts 0 .. NUM_LANES
  localparam int KF_MIN    = 2;

  localparam logic [CFG_W-1:0]  CFG_RESET = 4'd8;
  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
  localparam logic [FRAC_W-1:0] FRAC_ZERO = 17'h00000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TIME = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [TIME_W-1:0]       ktime_t;

  typedef struct packed {
    ktime_t t;
    val_t   x;
    val_t   y;
    val_t   z;
    val_t   yaw;
    val_t   pitch;
  } keyframe_t;

  typedef struct packed {
    val_t             x;
    val_t             y;
    val_t             z;
    val_t             yaw;
    val_t             pitch;
    logic             complete;
    logic [SEG_W-1:0] segment;
  } pose_t;

  typedef enum logic [1:0] {
    RD_NEXT = 2'd0,
    RD_IA   = 2'd1,
    RD_IB   = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic              ld_key;
    logic              take_time;
    logic              adv;
    logic              lat_a;
    logic              prep;
    logic              div_start;
    logic              take_quo;
    logic              mul_en;
    logic              acc_en;
    logic [LANE_W-1:0] lane;
    rd_sel_t           rd_sel;
    logic              ld_out;
  } kpi_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } kpi_sts_t;

endpackage

>>> rtl/kpi_in_if.sv
// Input channel: valid/ready handshake carrying a load item or a time item.
// Depends on kpi_pkg for field widths.
interface kpi_in_if;
  import kpi_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] key_index;
  ktime_t           key_time;
  val_t             key_x;
  val_t             key_y;
  val_t             key_z;
  val_t             key_yaw;
  val_t             key_pitch;
  ktime_t           now_time;

  modport source (
    output valid, operation, key_index, key_time, key_x, key_y, key_z,
           key_yaw, key_pitch, now_time,
    input  ready
  );

  modport sink (
    input  valid, operation, key_index, key_time, key_x, key_y, key_z,
           key_yaw, key_pitch, now_time,
    output ready
  );
endinterface

>>> rtl/kpi_out_if.sv
// Result channel: valid/ready handshake carrying one camera pose.
// Depends on kpi_pkg for field widths.
interface kpi_out_if;
  import kpi_pkg::*;

  logic             valid;
  logic             ready;
  val_t             cam_x;
  val_t             cam_y;
  val_t             cam_z;
  val_t             cam_yaw;
  val_t             cam_pitch;
  logic             track_complete;
  logic [SEG_W-1:0] segment;

  modport source (
    output valid, cam_x, cam_y, cam_z, cam_yaw, cam_pitch, track_complete, segment,
    input  ready
  );

  modport sink (
    input  valid, cam_x, cam_y, cam_z, cam_yaw, cam_pitch, track_complete, segment,
    output ready
  );
endinterface

>>> rtl/kpi_divider.sv
// Restoring serial divider for the interpolation fraction, one quotient bit per cycle.
// Requires 0 < num < den; returns floor(num * 2^16 / den). Depends on kpi_pkg.
module kpi_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [kpi_pkg::TIME_W-1:0]     num,
  input  logic [kpi_pkg::TIME_W-1:0]     den,
  output logic [kpi_pkg::FRAC_BITS-1:0]  quo,
  output logic                           done
);
  import kpi_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    rem_r;
  logic [TIME_W-1:0]    den_r;
  logic [FRAC_BITS-1:0] quo_r;
  logic [TIME_W:0]      rem2;
  logic [TIME_W:0]      diff;
  logic                 ge;

  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, den_r};
  assign ge   = (rem2 >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      // remainder stays below den, so it fits back into TIME_W bits
      rem_r <= ge ? diff[TIME_W-1:0] : rem2[TIME_W-1:0];
      quo_r <= {quo_r[FRAC_BITS-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule

>>> rtl/kpi_datapath.sv
// Datapath: keyframe table, segment cursor, fraction setup, shared multiplier and
// result register. Driven by kpi_ctrl commands; instantiates kpi_divider. Depends on kpi_pkg.
module kpi_datapath #(
  parameter int MAX_KEYFRAMES = kpi_pkg::KPI_MAX_KEYFRAMES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [kpi_pkg::CFG_W-1:0]   cfg_wr_data,
  input  kpi_pkg::keyframe_t          in_key,
  input  logic [kpi_pkg::IDX_W-1:0]   in_key_index,
  input  kpi_pkg::ktime_t             in_now_time,
  input  kpi_pkg::kpi_cmd_t           cmd,
  output kpi_pkg::kpi_sts_t           sts,
  output kpi_pkg::pose_t              pose
);
  import kpi_pkg::*;

  localparam int CW        = $clog2(MAX_KEYFRAMES);
  localparam int NW        = ($clog2(MAX_KEYFRAMES + 1) > CFG_W) ?
                             $clog2(MAX_KEYFRAMES + 1) : CFG_W;
  localparam int MOD_STEPS = (2 ** IDX_W) / 2;
  localparam int PROD_W    = VAL_W + 1 + FRAC_W + 1;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2 ** (FRAC_BITS - 1));

  // configuration and control state
  logic [CFG_W-1:0] kf_used_r;
  logic [CW-1:0]    cursor_r;
  logic             done_r;

  // table
  keyframe_t        kf_mem [MAX_KEYFRAMES];
  keyframe_t        rd_data_r;
  logic [CW-1:0]    rd_addr;
  logic [CW-1:0]    wr_slot;
  logic [NW-1:0]    slot_full;

  // item working registers
  ktime_t           now_r;
  ktime_t           a_time_r;
  val_t             a_v_r [NUM_LANES];
  val_t             b_v_r [NUM_LANES];
  logic [FRAC_W-1:0] f_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [LANE_W-1:0] prod_lane_r;
  val_t             a_sel_r;
  val_t             res_r [NUM_LANES];
  pose_t            pose_r;

  // combinational helpers
  logic [NW-1:0]    cfg_ext;
  logic [NW-1:0]    used_n;
  logic [NW-1:0]    last_n;
  logic [NW-1:0]    cur_ext;
  logic [NW-1:0]    cur_inc;
  logic [NW-1:0]    cur_adv;
  logic             adv_take;
  logic [CW-1:0]    ia;
  logic [CW-1:0]    ib;
  logic signed [TIME_W:0] num_s;
  logic signed [TIME_W:0] den_s;
  logic             need_div;
  logic [FRAC_W-1:0] f_special;
  logic [FRAC_BITS-1:0] div_quo;
  logic             div_done;
  val_t             a_lane;
  val_t             b_lane;
  logic signed [VAL_W:0]  d_s;
  logic signed [FRAC_W:0] f_s;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] q_s;
  logic [CW+SEG_W-1:0] cur_wide;

  // clamp the keyframe count to [2, MAX_KEYFRAMES]
  assign cfg_ext = NW'(kf_used_r);
  always_comb begin
    priority if (cfg_ext < NW'(KF_MIN)) begin
      used_n = NW'(KF_MIN);
    end else if (cfg_ext > NW'(MAX_KEYFRAMES)) begin
      used_n = NW'(MAX_KEYFRAMES);
    end else begin
      used_n = cfg_ext;
    end
  end
  assign last_n  = used_n - NW'(1);
  assign cur_ext = NW'(cursor_r);
  assign cur_inc = cur_ext + NW'(1);

  // key_index modulo table depth; key_index is narrow, a few subtractions cover it
  always_comb begin
    slot_full = NW'(in_key_index);
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (slot_full >= NW'(MAX_KEYFRAMES)) begin
        slot_full = slot_full - NW'(MAX_KEYFRAMES);
      end
    end
  end
  assign wr_slot = slot_full[CW-1:0];

  assign ia = done_r ? last_n[CW-1:0] : cursor_r;
  assign ib = done_r ? last_n[CW-1:0] : cur_inc[CW-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NEXT: rd_addr = cur_inc[CW-1:0];
      RD_IA:   rd_addr = ia;
      RD_IB:   rd_addr = ib;
      default: rd_addr = cursor_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_key) begin
      kf_mem[wr_slot] <= in_key;
    end
    rd_data_r <= kf_mem[rd_addr];
  end

  // advance by at most one keyframe; rd_data_r holds the entry after the cursor
  assign adv_take = (cur_inc < used_n) && (rd_data_r.t <= now_r);
  assign cur_adv  = adv_take ? cur_inc : cur_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kf_used_r <= CFG_RESET;
      cursor_r  <= '0;
      done_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        kf_used_r <= cfg_wr_data;
      end
      if (cmd.adv && !done_r) begin
        cursor_r <= cur_adv[CW-1:0];
        if (cur_adv >= last_n) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // fraction setup; rd_data_r holds the far keyframe during prep
  assign num_s = $signed({1'b0, now_r}) - $signed({1'b0, a_time_r});
  assign den_s = $signed({1'b0, rd_data_r.t}) - $signed({1'b0, a_time_r});
  assign need_div = (den_s > 0) && (num_s > 0) && (num_s < den_s);

  always_comb begin
    priority if (den_s <= 0) begin
      f_special = FRAC_ONE;
    end else if (num_s <= 0) begin
      f_special = FRAC_ZERO;
    end else begin
      f_special = FRAC_ONE;
    end
  end

  kpi_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_s[TIME_W-1:0]),
    .den   (den_s[TIME_W-1:0]),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign sts.need_div = need_div;
  assign sts.div_done = div_done;

  // one shared multiplier: lane k multiplies while lane k-1 rounds and adds
  assign a_lane = a_v_r[cmd.lane];
  assign b_lane = b_v_r[cmd.lane];
  assign d_s    = $signed({b_lane[VAL_W-1], b_lane}) - $signed({a_lane[VAL_W-1], a_lane});
  assign f_s    = $signed({1'b0, f_r});
  assign rnd    = prod_r + RND_HALF;
  assign q_s    = rnd >>> FRAC_BITS;

  assign cur_wide = (CW + SEG_W)'(cursor_r);

  always_ff @(posedge clk) begin
    if (cmd.take_time) begin
      now_r <= in_now_time;
    end
    if (cmd.lat_a) begin
      a_time_r <= rd_data_r.t;
      a_v_r[0] <= rd_data_r.x;
      a_v_r[1] <= rd_data_r.y;
      a_v_r[2] <= rd_data_r.z;
      a_v_r[3] <= rd_data_r.yaw;
      a_v_r[4] <= rd_data_r.pitch;
    end
    if (cmd.prep) begin
      b_v_r[0] <= rd_data_r.x;
      b_v_r[1] <= rd_data_r.y;
      b_v_r[2] <= rd_data_r.z;
      b_v_r[3] <= rd_data_r.yaw;
      b_v_r[4] <= rd_data_r.pitch;
      f_r      <= f_special;
    end
    if (cmd.take_quo) begin
      f_r <= {1'b0, div_quo};
    end
    if (cmd.mul_en) begin
      prod_r      <= PROD_W'(d_s) * PROD_W'(f_s);
      prod_lane_r <= cmd.lane;
      a_sel_r     <= a_lane;
    end
    if (cmd.acc_en) begin
      // the sum stays between the two keyframe values, so wraparound is exact
      res_r[prod_lane_r] <= a_sel_r + q_s[VAL_W-1:0];
    end
    if (cmd.ld_out) begin
      pose_r.x        <= res_r[0];
      pose_r.y        <= res_r[1];
      pose_r.z        <= res_r[2];
      pose_r.yaw      <= res_r[3];
      pose_r.pitch    <= res_r[4];
      pose_r.complete <= done_r;
      pose_r.segment  <= cur_wide[SEG_W-1:0];
    end
  end

  assign pose = pose_r;
endmodule

>>> rtl/kpi_ctrl.sv
// Controller: sequences table reads, cursor update, fraction divide and the
// five interpolation lanes, and owns the handshakes. Depends on kpi_pkg.
module kpi_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_operation,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output kpi_pkg::kpi_cmd_t    cmd,
  input  kpi_pkg::kpi_sts_t    sts
);
  import kpi_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ADV  = 8'b0000_0010,
    S_RDA  = 8'b0000_0100,
    S_RDB  = 8'b0000_1000,
    S_PREP = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_LERP = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_NEXT;
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        // the table read of the next entry runs here, ahead of the cursor update
        if (in_valid) begin
          if (in_operation == OP_LOAD) begin
            cmd.ld_key = 1'b1;
          end else begin
            cmd.take_time = 1'b1;
            state_nxt     = S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        cmd.rd_sel = RD_IA;
        state_nxt  = S_RDB;
      end
      S_RDB: begin
        cmd.rd_sel = RD_IB;
        cmd.lat_a  = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        lane_nxt = '0;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_LERP;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.take_quo = 1'b1;
          state_nxt    = S_LERP;
        end
      end
      S_LERP: begin
        cmd.lane   = lane_r;
        cmd.mul_en = (lane_r != LANE_W'(NUM_LANES));
        cmd.acc_en = (lane_r != '0);
        if (lane_r == LANE_W'(NUM_LANES)) begin
          state_nxt = S_OUT;
        end else begin
          lane_nxt = lane_r + LANE_W'(1);
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

>>> rtl/keyframe_path_interpolator.sv
// Keyframe path interpolator. A load item writes one keyframe (time, x, y, z, yaw,
// pitch) into the table. A time item moves the segment cursor forward by at most one
// keyframe and returns the linearly interpolated camera pose, or the last keyframe's
// pose once the track is complete. When the fraction lies strictly between 0 and 1 the
// item goes through the 16-step serial divider; the table's single read port adds three
// reads per item and the five pose values share one multiplier. The result register lets
// the next item in while a pose waits to be taken. Write keyframes_in_use only while idle.
// Depends on kpi_pkg, kpi_in_if, kpi_out_if, kpi_ctrl, kpi_datapath.
module keyframe_path_interpolator #(
  parameter int MAX_KEYFRAMES = kpi_pkg::KPI_MAX_KEYFRAMES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  kpi_in_if.sink                     in_if,
  kpi_out_if.source                  out_if,
  input  logic                       cfg_wr_en,
  input  logic [kpi_pkg::CFG_W-1:0]  cfg_wr_data
);
  import kpi_pkg::*;

  kpi_cmd_t  cmd;
  kpi_sts_t  sts;
  keyframe_t in_key;
  pose_t     pose;
  logic      out_valid;

  assign in_key.t     = in_if.key_time;
  assign in_key.x     = in_if.key_x;
  assign in_key.y     = in_if.key_y;
  assign in_key.z     = in_if.key_z;
  assign in_key.yaw   = in_if.key_yaw;
  assign in_key.pitch = in_if.key_pitch;

  kpi_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_operation (in_if.operation),
    .in_ready     (in_if.ready),
    .out_ready    (out_if.ready),
    .out_valid    (out_valid),
    .cmd          (cmd),
    .sts          (sts)
  );

  kpi_datapath #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_key       (in_key),
    .in_key_index (in_if.key_index),
    .in_now_time  (in_if.now_time),
    .cmd          (cmd),
    .sts          (sts),
    .pose         (pose)
  );

  assign out_if.valid          = out_valid;
  assign out_if.cam_x          = pose.x;
  assign out_if.cam_y          = pose.y;
  assign out_if.cam_z          = pose.z;
  assign out_if.cam_yaw        = pose.yaw;
  assign out_if.cam_pitch      = pose.pitch;
  assign out_if.track_complete = pose.complete;
  assign out_if.segment        = pose.segment;

  // a time transfer closes the input until its result is placed
  a_time_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.operation == OP_TIME) |=> !in_if.ready)
    else $error("input still open after a time transfer");

  // a load transfer never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.operation == OP_LOAD && !out_if.valid)
      |=> !out_if.valid)
    else $error("result appeared after a load transfer");

  // a new result is placed only from the output step, never while idle
  a_result_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> !$past(in_if.ready))
    else $error("result placed while input was open");

  // the divider is started only for a fraction strictly inside (0, 1)
  a_div_start_needed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.need_div)
    else $error("divider started without need");
endmodule
